/* src/psnr_pkg.sv */
// Package for the pixel signal-to-noise block: word types, field widths,
// outcome codes and the token that runs down the cell chain. No dependencies.
package psnr_pkg;

  localparam int SAMPLE_W      = 32;
  localparam int VAR_W         = 32;
  localparam int RATIO_W       = 48;
  localparam int FRAC_W        = 16;
  localparam int RES_W         = 2 * SAMPLE_W - 2 + 2 * FRAC_W + 1;
  localparam int PROD_W        = RATIO_W + VAR_W;
  localparam int D_W           = 2 * RATIO_W + VAR_W + 1;
  localparam int SAMPLE_W_DEF  = 32;

  localparam logic [1:0] OUTCOME_GOOD = 2'd0;
  localparam logic [1:0] OUTCOME_BAD  = 2'd1;
  localparam logic [1:0] OUTCOME_LOW  = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_bad;
    logic [VAR_W-1:0]           variance;
    logic                       variance_bad;
  } psnr_in_t;

  typedef struct packed {
    logic signed [RATIO_W-1:0] ratio;
    logic [1:0]                outcome;
  } psnr_out_t;

  // Per-word state held in each cell: residual a*a - q*q*v, running q*v.
  typedef struct packed {
    logic               valid;
    logic [1:0]         outcome;
    logic               neg;
    logic [RATIO_W-1:0] q;
    logic [PROD_W-1:0]  y;
    logic [RES_W-1:0]   r;
    logic [VAR_W-1:0]   v;
  } psnr_tok_t;

endpackage

/* src/psnr_front.sv */
// Front end: bad-flag and threshold checks, sample magnitude, and the
// squared scaled magnitude that seeds the cell chain. Uses psnr_pkg.
module psnr_front import psnr_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  psnr_in_t         item,
  input  logic [VAR_W-1:0] min_variance,
  output psnr_tok_t        tok
);

  localparam int SW = SAMPLE_WIDTH;

  logic             s1_valid;
  logic [1:0]       s1_outcome;
  logic             s1_neg;
  logic [SAMPLE_W-1:0] s1_mag;
  logic [VAR_W-1:0] s1_v;

  logic [VAR_W-1:0]    thr;
  logic [SW-1:0]       field;
  logic [SAMPLE_W-1:0] mag_next;
  logic [1:0]          outcome_next;
  logic [2*SAMPLE_W-1:0] sq;

  always_comb begin
    thr   = (min_variance == '0) ? VAR_W'(1) : min_variance;
    field = item.sample[SW-1:0];
    if (field[SW-1]) begin
      mag_next = SAMPLE_W'(-$signed(field)) & SAMPLE_W'((64'd1 << SW) - 64'd1);
    end else begin
      mag_next = SAMPLE_W'(field);
    end
    if (item.sample_bad || item.variance_bad) begin
      outcome_next = OUTCOME_BAD;
    end else if (item.variance < thr) begin
      outcome_next = OUTCOME_LOW;
    end else begin
      outcome_next = OUTCOME_GOOD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      tok.valid <= 1'b0;
    end else begin
      s1_valid <= load;
      tok.valid <= s1_valid;
    end
    s1_outcome <= outcome_next;
    s1_neg     <= field[SW-1];
    s1_mag     <= mag_next;
    s1_v       <= item.variance;
    tok.outcome <= s1_outcome;
    tok.neg     <= s1_neg;
    tok.q       <= '0;
    tok.y       <= '0;
    tok.v       <= s1_v;
    tok.r       <= RES_W'({sq, {(2*FRAC_W){1'b0}}});
  end

  assign sq = s1_mag * s1_mag;

endmodule

/* src/psnr_cell.sv */
// One cell of the root-quotient chain: decides one bit of q and updates the
// residual and running product. Uses psnr_pkg.
module psnr_cell import psnr_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  psnr_tok_t tin,
  output psnr_tok_t tout
);

  logic [D_W-1:0]    d;
  logic              take;
  psnr_tok_t         t_next;

  // Setting bit b raises q*q*v by (q*v << (b+1)) + (v << 2b).
  always_comb begin
    d      = (D_W'(tin.y) << (BIT + 1)) + (D_W'(tin.v) << (2 * BIT));
    take   = d <= D_W'(tin.r);
    t_next = tin;
    if (take) begin
      t_next.q[BIT] = 1'b1;
      t_next.r      = tin.r - d[RES_W-1:0];
      t_next.y      = tin.y + (PROD_W'(tin.v) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
    end else begin
      tout.valid <= tin.valid;
    end
    tout.outcome <= t_next.outcome;
    tout.neg     <= t_next.neg;
    tout.q       <= t_next.q;
    tout.y       <= t_next.y;
    tout.r       <= t_next.r;
    tout.v       <= t_next.v;
  end

endmodule

/* src/pixel_signal_to_noise_ratio.sv */
// Top level of the pixel signal-to-noise block: front end, chain of
// quotient cells and result register. Uses psnr_pkg, psnr_front, psnr_cell.
//
// A pixel word is taken on item at a clock edge with start high; busy is
// always low, so one word may enter every cycle and the throughput is one
// pixel per clock. Each word yields exactly one result word on result,
// shown for one cycle with done high as it leaves the output register.
// The path has 51 register stages: two front-end stages (checks, then the
// squared sample), one cell per ratio bit (48 cells, each deciding one bit
// of the Q32.16 magnitude), and the output register.
// Results leave in the order the words came in.
// The receiver cannot stall the block; it must take each result when done
// is high. min_variance is written with cfg_we and cfg_wdata while no word
// is in flight; a value of zero acts as one. Reset clears the pipeline
// valid bits, drops done, and sets min_variance to one.
module pixel_signal_to_noise_ratio import psnr_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  psnr_in_t         item,
  input  logic             cfg_we,
  input  logic [VAR_W-1:0] cfg_wdata,
  output logic             done,
  output psnr_out_t        result
);

  logic [VAR_W-1:0] min_variance;
  psnr_tok_t        chain [RATIO_W+1];
  psnr_tok_t        last;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_variance <= VAR_W'(1);
    end else if (cfg_we) begin
      min_variance <= cfg_wdata;
    end
  end

  psnr_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .load         (start),
    .item         (item),
    .min_variance (min_variance),
    .tok          (chain[0])
  );

  for (genvar i = 0; i < RATIO_W; i++) begin : g_cell
    psnr_cell #(.BIT(RATIO_W - 1 - i)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .tin  (chain[i]),
      .tout (chain[i+1])
    );
  end

  assign last = chain[RATIO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
    result.outcome <= last.outcome;
    if (last.outcome != OUTCOME_GOOD) begin
      result.ratio <= '0;
    end else if (last.neg) begin
      result.ratio <= -$signed(last.q);
    end else begin
      result.ratio <= $signed(last.q);
    end
  end

endmodule

/* tb/pixel_signal_to_noise_ratio_checker.sv */
// Checker for the pixel signal-to-noise block: watches accepted pixel words and
// result words, predicts each result and compares it. Depends on psnr_pkg.
`timescale 1ns / 100ps

module pixel_signal_to_noise_ratio_checker import psnr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  psnr_in_t         item,
  input  logic             cfg_we,
  input  logic [VAR_W-1:0] cfg_wdata,
  input  logic             done,
  input  psnr_out_t        result,
  output int               fail_count,
  output int               pending
);

  logic [VAR_W-1:0] threshold;
  psnr_out_t        expected_q[$];

  // Bitwise search for the largest q with q*q*v <= a*a, done on wide vectors.
  function automatic logic [RATIO_W-1:0] root_quotient(logic [RATIO_W-1:0] a,
                                                       logic [VAR_W-1:0] v);
    logic [RATIO_W-1:0] q;
    logic [RATIO_W-1:0] t;
    logic [191:0]       lhs;
    logic [191:0]       rhs;
    q = '0;
    rhs = 192'(a) * 192'(a);
    for (int b = RATIO_W - 1; b >= 0; b--) begin
      t = q | (48'd1 << b);
      lhs = 192'(t) * 192'(t) * 192'(v);
      if (lhs <= rhs) q = t;
    end
    return q;
  endfunction

  function automatic psnr_out_t predict_ratio(psnr_in_t px, logic [VAR_W-1:0] thr);
    psnr_out_t          r;
    logic [VAR_W-1:0]   eff;
    logic [RATIO_W-1:0] mag;
    logic               neg;
    r = '0;
    eff = (thr == 0) ? 32'd1 : thr;
    if (px.sample_bad || px.variance_bad) begin
      r.outcome = OUTCOME_BAD;
    end else if (px.variance < eff) begin
      r.outcome = OUTCOME_LOW;
    end else begin
      neg = px.sample[SAMPLE_W-1];
      mag = neg ? RATIO_W'(-(64'(signed'(px.sample)))) : RATIO_W'(px.sample);
      mag = root_quotient(mag << FRAC_W, px.variance);
      r.ratio = neg ? -mag : mag;
      r.outcome = OUTCOME_GOOD;
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    psnr_out_t want;
    int        errs;
    errs = 0;
    if (rst) begin
      threshold <= 32'd1;
      fail_count <= 0;
    end else begin
      if (cfg_we) threshold <= cfg_wdata;
      if (start && !busy) expected_q.push_back(predict_ratio(item, threshold));
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word: ratio %0d outcome %0d", result.ratio,
                 result.outcome);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (want.ratio !== result.ratio) begin
            $error("ratio: expected %0d, got %0d", want.ratio, result.ratio);
            errs++;
          end
          if (want.outcome !== result.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, result.outcome);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

/* tb/pixel_signal_to_noise_ratio_tb.sv */
// Testbench top for the pixel signal-to-noise block: drives pixel words and
// threshold writes, gives the verdict. Depends on psnr_pkg and the checker.
`timescale 1ns / 100ps

module pixel_signal_to_noise_ratio_tb;
  import psnr_pkg::*;

  localparam int LATENCY = 51;
  localparam int IDLE_LIMIT = 2000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  psnr_in_t         item;
  logic             cfg_we;
  logic [VAR_W-1:0] cfg_wdata;
  logic             done;
  psnr_out_t        result;
  int               fail_count;
  int               pending;
  int               idle_cycles;

  pixel_signal_to_noise_ratio dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
  );

  pixel_signal_to_noise_ratio_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Watchdog on cycles without any accepted word or result word.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      2: return 32'h8000_0000 + $urandom_range(0, 15) - 8;
      3: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Sends one pixel word and holds it until the edge that takes it. With no
  // gap, start stays high so the next word follows back to back.
  task automatic send_pixel(logic [31:0] s, logic sb, logic [31:0] v, logic vb);
    int gap;
    gap = gap_length();
    item <= '{sample: s, sample_bad: sb, variance: v, variance_bad: vb};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int count);
    logic [31:0] v;
    for (int n = 0; n < count; n++) begin
      v = random_value();
      // Mostly good pixels; the bad flags and tiny variances come now and then.
      send_pixel(random_value(), $urandom_range(0, 9) == 0, v,
                 $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset threshold of one.
    send_pixel(32'h8000_0000, 0, 32'd1, 0);
    send_pixel(32'h7FFF_FFFF, 0, 32'd1, 0);
    send_pixel(32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 0);
    send_pixel(32'h8000_0000, 0, 32'hFFFF_FFFF, 0);
    send_pixel(32'd0, 0, 32'd7, 0);
    send_pixel(32'hFFFF_FFFF, 0, 32'd2, 0);
    send_pixel(32'd5, 0, 32'd0, 0);
    send_pixel(32'd5, 1, 32'd9, 0);
    send_pixel(32'd5, 0, 32'd9, 1);
    send_pixel(32'd5, 1, 32'd0, 1);
    send_pixel(32'd100, 0, 32'd4, 0);
    send_pixel(-32'sd100, 0, 32'd3, 0);
    drain();

    // Zero threshold acts as one.
    write_threshold(32'd0);
    send_pixel(32'd3, 0, 32'd0, 0);
    send_pixel(32'd3, 0, 32'd1, 0);
    drain();

    write_threshold(32'hFFFF_FFFF);
    send_pixel(32'd3, 0, 32'hFFFF_FFFE, 0);
    send_pixel(32'h8000_0000, 0, 32'hFFFF_FFFF, 0);
    send_pixel(32'd3, 1, 32'd0, 0);
    drain();

    write_threshold(32'd1);
    random_phase(600);
    drain();
    write_threshold(32'd16);
    random_phase(400);
    drain();
    write_threshold(32'h8000_0000);
    random_phase(400);
    drain();
    write_threshold($urandom);
    random_phase(430);
    drain();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
